/* rtl/core/sfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and codes for the sync 0x68 frame deframer
// Result item layout, result kinds and fixed frame constants.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0]  SYNC_BYTE            = 8'h68;
  localparam int          FRAME_OVERHEAD_BYTES = 7;
  localparam int          SEGMENT_START        = 11;
  localparam int          SPLIT_THRESHOLD      = 14;
  localparam int          OUT_DEPTH_DEFAULT    = 8;

  // register indexes on the config port
  localparam logic        REG_MIN_LEN  = 1'b0;
  localparam logic        REG_MAX_LEN  = 1'b1;

  localparam logic [1:0]  KIND_TYPE    = 2'd0;
  localparam logic [1:0]  KIND_DATA    = 2'd1;
  localparam logic [1:0]  KIND_VERDICT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] seg_length;
    logic        seg_last;
    logic        crc_ok;
    logic        truncated;
  } sfd_res_t;

  // results caused by one byte, slot 0 first
  typedef struct packed {
    logic [1:0] count;
    sfd_res_t   r0;
    sfd_res_t   r1;
  } sfd_push_t;

endpackage

/* rtl/core/sfd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core: input register, sync search, CRC and segment splitter
// One registered byte is processed per cycle; its results go out as a bundle.
// ----------------------------------------------------------------------------
module sfd_core
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_take,
  input  logic [7:0]  in_byte,
  output logic        in_pending,
  output sfd_push_t   push
);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LENH = 2'd1;
  localparam logic [1:0] PH_LENL = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  logic [15:0] min_len, max_len;
  logic        in_v;
  logic [7:0]  in_b;

  logic [23:0] win, win_next;
  logic [1:0]  fill, fill_next;
  logic        locked, locked_next;
  logic [16:0] pos, pos_next;
  logic [16:0] total, total_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_hi, crc_hi_next;
  logic        split, split_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] rem, rem_next;
  // CRC of the newest window byte, and of the newest two, from 0xFFFF
  logic [15:0] crc1, crc1_next;
  logic [15:0] pair, pair_next;

  logic [15:0] hdr_len;
  logic [15:0] crc_new;
  logic [1:0]  phase_new;
  logic [15:0] rem_new;
  logic [15:0] rem_dec;
  logic [15:0] seg_len;
  logic [16:0] pos_p1, pos_p2, pos_p3, pos_p4;
  logic [1:0]  n;
  sfd_res_t    verdict;

  assign in_pending = in_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= 16'd1;
      max_len <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEN: min_len <= cfg_data;
        REG_MAX_LEN: max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= in_take;
    end
    if (in_take) begin
      in_b <= in_byte;
    end
  end

  assign hdr_len = win[15:0];
  assign pos_p1  = pos + 17'd1;
  assign pos_p2  = pos + 17'd2;
  assign pos_p3  = pos + 17'd3;
  assign pos_p4  = pos + 17'd4;
  assign rem_dec = rem - 16'd1;
  assign seg_len = {rem[7:0], in_b};

  always_comb begin
    win_next    = win;
    fill_next   = fill;
    locked_next = locked;
    pos_next    = pos;
    total_next  = total;
    crc_next    = crc;
    crc_hi_next = crc_hi;
    split_next  = split;
    phase_next  = phase;
    rem_next    = rem;
    crc1_next   = crc1;
    pair_next   = pair;
    crc_new     = crc;
    phase_new   = phase;
    rem_new     = rem;
    n           = 2'd0;
    push        = '0;
    verdict     = '0;

    if (in_v && !locked) begin
      if (fill == 2'd3 && win[23:16] == SYNC_BYTE && in_b == SYNC_BYTE &&
          hdr_len >= min_len && hdr_len <= max_len) begin
        locked_next = 1'b1;
        total_next  = {1'b0, hdr_len} + 17'(FRAME_OVERHEAD_BYTES);
        pos_next    = 17'd4;
        crc_next    = crc16_byte(pair, in_b);
        crc_hi_next = 8'h00;
        split_next  = ({1'b0, hdr_len} + 17'(FRAME_OVERHEAD_BYTES)) > 17'(SPLIT_THRESHOLD);
        phase_next  = PH_TYPE;
        rem_next    = 16'h0000;
        win_next    = 24'h000000;
        fill_next   = 2'd0;
      end else begin
        fill_next = (fill == 2'd3) ? 2'd3 : fill + 2'd1;
        win_next  = {win[15:0], in_b};
        crc1_next = crc16_byte(16'hFFFF, in_b);
        pair_next = crc16_byte(crc1, in_b);
      end
    end else if (in_v) begin
      if (pos_p4 <= total) begin
        crc_new = crc16_byte(crc, in_b);
      end else if (pos_p3 == total) begin
        crc_hi_next = in_b;
      end else if (pos_p2 == total) begin
        crc_new = crc ^ {crc_hi, in_b};
      end

      if (split) begin
        case (phase)
          PH_TYPE: begin
            if (pos >= 17'(SEGMENT_START) && pos_p3 < total) begin
              rem_new   = {in_b, 8'h00};
              phase_new = PH_LENH;
            end
          end
          PH_LENH: begin
            rem_new   = {rem[15:8], in_b};
            phase_new = PH_LENL;
          end
          PH_LENL: begin
            push.r0.kind       = KIND_TYPE;
            push.r0.value      = rem[15:8];
            push.r0.seg_length = seg_len;
            push.r0.seg_last   = (seg_len == 16'h0000);
            n                  = 2'd1;
            rem_new            = seg_len;
            phase_new          = (seg_len == 16'h0000) ? PH_TYPE : PH_DATA;
          end
          default: begin
            push.r0.kind     = KIND_DATA;
            push.r0.value    = in_b;
            push.r0.seg_last = (rem_dec == 16'h0000);
            n                = 2'd1;
            rem_new          = rem_dec;
            if (rem_dec == 16'h0000) begin
              phase_new = PH_TYPE;
            end
          end
        endcase
      end

      if (pos_p1 >= total) begin
        verdict.kind      = KIND_VERDICT;
        verdict.crc_ok    = (crc_new == 16'h0000);
        verdict.truncated = split && (phase_new != PH_TYPE);
        if (n == 2'd0) begin
          push.r0 = verdict;
        end else begin
          push.r1 = verdict;
        end
        n           = n + 2'd1;
        win_next    = 24'h000000;
        fill_next   = 2'd0;
        locked_next = 1'b0;
        pos_next    = 17'd0;
        total_next  = 17'd0;
        crc_next    = 16'hFFFF;
        crc_hi_next = 8'h00;
        split_next  = 1'b0;
        phase_next  = PH_TYPE;
        rem_next    = 16'h0000;
      end else begin
        pos_next   = pos_p1;
        crc_next   = crc_new;
        phase_next = phase_new;
        rem_next   = rem_new;
      end
    end
    push.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win    <= 24'h000000;
      fill   <= 2'd0;
      locked <= 1'b0;
      pos    <= 17'd0;
      total  <= 17'd0;
      crc    <= 16'hFFFF;
      crc_hi <= 8'h00;
      split  <= 1'b0;
      phase  <= PH_TYPE;
      rem    <= 16'h0000;
    end else begin
      win    <= win_next;
      fill   <= fill_next;
      locked <= locked_next;
      pos    <= pos_next;
      total  <= total_next;
      crc    <= crc_next;
      crc_hi <= crc_hi_next;
      split  <= split_next;
      phase  <= phase_next;
      rem    <= rem_next;
    end
    crc1 <= crc1_next;
    pair <= pair_next;
  end

endmodule

/* rtl/core/sfd_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_outq: result queue
// Takes up to two result items a cycle, hands out one. DEPTH a power of two.
// ----------------------------------------------------------------------------
module sfd_outq
  import sfd_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfd_push_t                  push,
  input  logic                       pop,
  output sfd_res_t                   head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  sfd_res_t        mem [DEPTH];
  logic [AW-1:0]   wr, rd;

  assign not_empty = (level != '0);
  assign head      = mem[rd];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      level <= '0;
    end else begin
      wr    <= wr + AW'(push.count);
      rd    <= rd + AW'(pop);
      level <= level + LW'(push.count) - LW'(pop);
    end
  end

endmodule

/* rtl/core/sync68_frame_deframer_crc16.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync68_frame_deframer_crc16: 0x68 sync frame deframer, CRC-16 check, splitter
// Finds 0x68 LL LL 0x68 headers in a byte stream, checks the frame CRC and
// emits segment type, payload and end-of-frame verdict items.
// ----------------------------------------------------------------------------
// Use:
//   s_* : one received stream byte per item.
//   m_* : result items - segment type byte (with declared length), segment
//         payload byte, or the verdict on the frame's last byte.
//   cfg : min/max accepted length field, write while the block is idle.
// Timing:
//   One byte per cycle while s_tready is high. A byte accepted at one edge is worked on
//   in the next cycle, from the input register, by the sync/CRC/splitter
//   logic; its results enter the result queue at the end of that cycle and
//   are then taken from the head of the queue.
//   A byte yields at most two items (type or payload + verdict), which the queue
//   absorbs; s_tready drops only while the queue cannot take two more items
//   for the byte in flight and two more for the new byte.
// Reset: synchronous, clears the search window, frame state, queue and
//   restores min 1 / max 4096.
// Stall: while m_tready is low results wait in the queue; input keeps being
//   taken until the queue nears full, then s_tready is held low.
// ----------------------------------------------------------------------------
module sync68_frame_deframer_crc16
  import sfd_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  // result items out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] value, [23:8] seg_length, [24] crc_ok,
                                 // [25] truncated, [31:26] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // seg_last
);

  localparam int LW = $clog2(OUT_DEPTH+1);

  sfd_push_t   push;
  sfd_res_t    head;
  logic        in_pending;
  logic        q_not_empty;
  logic [LW-1:0] q_level;
  logic [LW+1:0] q_need;
  logic        take;

  // worst case: two items from the byte in flight, two from the new one
  assign q_need   = (LW+2)'(q_level) + (in_pending ? (LW+2)'(2) : (LW+2)'(0))
                  + (LW+2)'(2);
  assign s_tready = (q_need <= (LW+2)'(OUT_DEPTH));
  assign take     = s_tvalid && s_tready;

  sfd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_take    (take),
    .in_byte    (s_tdata),
    .in_pending (in_pending),
    .push       (push)
  );

  sfd_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  assign m_tvalid = q_not_empty;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.seg_last;
  assign m_tdata  = {6'b000000, head.truncated, head.crc_ok, head.seg_length, head.value};

  // queue never overfills given the admission check
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (LW+1)'(q_level) <= (LW+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  // a verdict carries no byte, length or segment end
  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_VERDICT) |-> (m_tdata[23:0] == 24'h0 && !m_tlast))
    else $error("verdict item with payload fields set");

  // every item's kind is one of the three known codes
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_TYPE || m_tuser == KIND_DATA || m_tuser == KIND_VERDICT))
    else $error("unknown result kind");

  // an empty queue with nothing in flight must accept
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    (q_level == '0 && !in_pending) |-> s_tready)
    else $error("input stalled with empty queue");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sync68_frame_deframer_crc16
// Drives framed and unframed byte streams with random gaps, keeps its own
// deframer/CRC/splitter model, and compares every result item field by field.
// ----------------------------------------------------------------------------
module testbench;
  import sfd_pkg::*;

  localparam logic [15:0] MIN_LEN_RESET  = 16'd1;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  // cycles to let the pipeline empty when the last byte caused no item
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 10;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    SEG_TYPE, SEG_LENH, SEG_LENL, SEG_DATA
  } seg_phase_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = 16'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  sync68_frame_deframer_crc16 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Deframer model: register copies and frame state
  // --------------------------------------------------------------------------
  logic [15:0] min_len;
  logic [15:0] max_len;
  logic [23:0] hunt_window;
  logic [1:0]  hunt_fill;
  logic        locked;
  logic [16:0] frame_pos;
  logic [16:0] frame_len_total;
  logic [15:0] frame_crc;
  logic [7:0]  crc_rx_high;
  logic        split_on;
  seg_phase_t  phase;
  logic [15:0] seg_left;

  sfd_res_t    expected_results[$];
  logic [7:0]  frame_bytes[$];
  int          error_count = 0;
  int          bytes_sent  = 0;
  bit          idling_on   = 1'b1;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  function automatic sfd_res_t result_item(input logic [1:0] kind, input logic [7:0] value,
                                           input logic [15:0] seg_length, input logic seg_last,
                                           input logic crc_ok, input logic truncated);
    sfd_res_t r;
    r.kind       = kind;
    r.value      = value;
    r.seg_length = seg_length;
    r.seg_last   = seg_last;
    r.crc_ok     = crc_ok;
    r.truncated  = truncated;
    return r;
  endfunction

  // back to hunting; the window restarts empty after every frame
  task automatic clear_frame_state();
    hunt_window     = '0;
    hunt_fill       = '0;
    locked          = 1'b0;
    frame_pos       = '0;
    frame_len_total = '0;
    frame_crc       = CRC_INIT;
    crc_rx_high     = '0;
    split_on        = 1'b0;
    phase           = SEG_TYPE;
    seg_left        = '0;
  endtask

  // works out the items one accepted byte causes and queues them
  task automatic deframe_predict(input logic [7:0] b);
    logic [15:0] hdr_len;
    logic [15:0] decl_len;
    hdr_len = hunt_window[15:0];
    if (!locked) begin
      if (hunt_fill == 2'd3 && hunt_window[23:16] == SYNC_BYTE && b == SYNC_BYTE &&
          hdr_len >= min_len && hdr_len <= max_len) begin
        // header found: total latched now, so later register writes cannot touch it
        clear_frame_state();
        locked          = 1'b1;
        frame_len_total = 17'(hdr_len) + 17'(FRAME_OVERHEAD_BYTES);
        frame_pos       = 17'd4;
        frame_crc       = crc16_update(crc16_update(crc16_update(CRC_INIT, hdr_len[15:8]),
                                                    hdr_len[7:0]), b);
        split_on        = frame_len_total > SPLIT_THRESHOLD;
      end else begin
        if (hunt_fill != 2'd3) hunt_fill = hunt_fill + 2'd1;
        hunt_window = {hunt_window[15:0], b};
      end
    end else begin
      // CRC over bytes 1..total-4, then fold in the received high/low bytes
      if (frame_pos + 4 <= frame_len_total) frame_crc = crc16_update(frame_crc, b);
      else if (frame_pos + 3 == frame_len_total) crc_rx_high = b;
      else if (frame_pos + 2 == frame_len_total) frame_crc = frame_crc ^ {crc_rx_high, b};

      if (split_on) begin
        case (phase)
          SEG_TYPE: begin
            if (frame_pos >= SEGMENT_START && frame_pos + 3 < frame_len_total) begin
              seg_left = {b, 8'h00};
              phase    = SEG_LENH;
            end
          end
          SEG_LENH: begin
            seg_left[7:0] = b;
            phase         = SEG_LENL;
          end
          SEG_LENL: begin
            decl_len = {seg_left[7:0], b};
            expected_results.push_back(result_item(KIND_TYPE, seg_left[15:8], decl_len,
                                                   decl_len == 16'd0, 1'b0, 1'b0));
            seg_left = decl_len;
            phase    = (decl_len == 16'd0) ? SEG_TYPE : SEG_DATA;
          end
          default: begin
            seg_left = seg_left - 16'd1;
            expected_results.push_back(result_item(KIND_DATA, b, 16'd0, seg_left == 16'd0,
                                                   1'b0, 1'b0));
            if (seg_left == 16'd0) phase = SEG_TYPE;
          end
        endcase
      end

      if (frame_pos + 1 >= frame_len_total) begin
        expected_results.push_back(result_item(KIND_VERDICT, 8'd0, 16'd0, 1'b0,
                                               frame_crc == 16'd0,
                                               split_on && phase != SEG_TYPE));
        clear_frame_state();
      end else begin
        frame_pos = frame_pos + 17'd1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    sfd_res_t got_item;
    sfd_res_t want_item;
    if (!rst && m_tvalid && m_tready) begin
      got_item = result_item(m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast,
                             m_tdata[24], m_tdata[25]);
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item, expected none, actual %h", $time, got_item);
      end else begin
        want_item = expected_results.pop_front();
        check_field("kind", 16'(want_item.kind), 16'(got_item.kind));
        check_field("value", 16'(want_item.value), 16'(got_item.value));
        check_field("seg_length", want_item.seg_length, got_item.seg_length);
        check_field("seg_last", 16'(want_item.seg_last), 16'(got_item.seg_last));
        check_field("crc_ok", 16'(want_item.crc_ok), 16'(got_item.crc_ok));
        check_field("truncated", 16'(want_item.truncated), 16'(got_item.truncated));
      end
    end
  end

  // receiver stalls in random bursts, with long stretches of none
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout, %0d items outstanding", $time, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 11) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_predict(b);
    bytes_sent++;
  endtask

  // sender holds off until every expected item has been taken
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain_pause();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MIN_LEN: min_len = val;
      default:     max_len = val;
    endcase
  endtask

  // builds a whole frame: header, filler up to the segment area, segments with
  // random content (occasionally declaring more than fits), CRC, end byte
  task automatic build_frame(input logic [15:0] len, input bit corrupt);
    logic [15:0] crc_acc;
    int          room;
    int          seg_len;
    int          fill;
    int          flip_at;
    frame_bytes.delete();
    frame_bytes.push_back(SYNC_BYTE);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(SYNC_BYTE);
    while (frame_bytes.size() < SEGMENT_START && frame_bytes.size() < int'(len) + 4)
      frame_bytes.push_back(8'($urandom));
    room = int'(len) + 4 - frame_bytes.size();
    while (room >= 3) begin
      frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 7) == 0) seg_len = $urandom_range(0, 65535);
      else seg_len = $urandom_range(0, (room - 3 < 24) ? room - 3 : 24);
      frame_bytes.push_back(8'(seg_len >> 8));
      frame_bytes.push_back(8'(seg_len));
      fill = (seg_len < room - 3) ? seg_len : room - 3;
      repeat (fill) frame_bytes.push_back(8'($urandom));
      room -= 3 + fill;
    end
    repeat (room) frame_bytes.push_back(8'($urandom));
    crc_acc = CRC_INIT;
    for (int i = 1; i < frame_bytes.size(); i++) crc_acc = crc16_update(crc_acc, frame_bytes[i]);
    frame_bytes.push_back(crc_acc[15:8]);
    frame_bytes.push_back(crc_acc[7:0]);
    frame_bytes.push_back(8'($urandom));
    if (corrupt) begin
      flip_at = $urandom_range(4, frame_bytes.size() - 2);
      frame_bytes[flip_at] = frame_bytes[flip_at] ^ (8'd1 << $urandom_range(0, 7));
    end
  endtask

  task automatic send_frame(input logic [15:0] len, input bit corrupt);
    build_frame(len, corrupt);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // line noise; sync bytes kept rare so a stray lock stays unlikely
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == SYNC_BYTE && $urandom_range(0, 15) != 0) b = ~b;
      send_byte(b);
    end
  endtask

  // header with both sync bytes but a length outside the accepted range, if one exists
  task automatic send_bad_header();
    logic [15:0] len;
    if (min_len > 16'd0 && (max_len == 16'hFFFF || $urandom_range(0, 1) == 0))
      len = 16'($urandom_range(0, int'(min_len) - 1));
    else if (max_len < 16'hFFFF)
      len = 16'($urandom_range(int'(max_len) + 1, 65535));
    else
      len = 16'd0;
    if (len < min_len || len > max_len) begin
      send_byte(SYNC_BYTE);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(SYNC_BYTE);
    end
    send_noise($urandom_range(1, 4));
  endtask

  // mostly short frames, now and then no split, now and then long ones;
  // pulled into the accepted range unless that range is empty
  function automatic logic [15:0] pick_length();
    int r;
    int span;
    logic [15:0] len;
    r = $urandom_range(0, 9);
    if (r < 2) len = 16'($urandom_range(0, 7));
    else if (r < 9) len = 16'($urandom_range(8, 40));
    else len = 16'($urandom_range(41, 160));
    if (min_len <= max_len && (len < min_len || len > max_len)) begin
      span = (int'(max_len) - int'(min_len) > 40) ? 40 : int'(max_len) - int'(min_len);
      len = min_len + 16'($urandom_range(0, span));
    end
    return len;
  endfunction

  task automatic stream_mix(input int n_bytes);
    int stop_at;
    int pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) send_frame(pick_length(), 1'b0);
      else if (pick < 16) send_frame(pick_length(), 1'b1);
      else if (pick < 18) send_noise($urandom_range(1, 12));
      else if (pick == 18) send_bad_header();
      else drain_pause();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // shortest legal frame, an oversize length field, and the shortest frame
  // that is split, whose only segment header runs into the CRC bytes
  task automatic test_directed();
    send_frame(16'd1, 1'b0);
    send_byte(SYNC_BYTE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);
    send_frame(16'd8, 1'b0);
  endtask

  // narrowing the range while a frame is open must not disturb that frame
  task automatic test_mid_frame_config();
    build_frame(16'd20, 1'b0);
    for (int i = 0; i < 10; i++) send_byte(frame_bytes[i]);
    write_reg(REG_MAX_LEN, 16'd5);
    write_reg(REG_MIN_LEN, 16'd3);
    for (int i = 10; i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
  endtask

  task automatic test_default_range();
    write_reg(REG_MIN_LEN, MIN_LEN_RESET);
    write_reg(REG_MAX_LEN, MAX_LEN_RESET);
    stream_mix(300);
  endtask

  task automatic test_wide_range();
    write_reg(REG_MIN_LEN, 16'd0);
    write_reg(REG_MAX_LEN, 16'hFFFF);
    stream_mix(250);
  endtask

  task automatic test_single_length();
    write_reg(REG_MIN_LEN, 16'd9);
    write_reg(REG_MAX_LEN, 16'd9);
    stream_mix(120);
  endtask

  // min above max: nothing may ever lock
  task automatic test_empty_range();
    write_reg(REG_MIN_LEN, 16'hFFFF);
    write_reg(REG_MAX_LEN, 16'd0);
    stream_mix(80);
  endtask

  // back-to-back bytes with the receiver always ready
  task automatic test_full_rate();
    idling_on = 1'b0;
    write_reg(REG_MIN_LEN, MIN_LEN_RESET);
    write_reg(REG_MAX_LEN, MAX_LEN_RESET);
    stream_mix(200);
  endtask

  initial begin
    min_len = MIN_LEN_RESET;
    max_len = MAX_LEN_RESET;
    clear_frame_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_mid_frame_config();
    test_default_range();
    test_wide_range();
    test_single_length();
    test_empty_range();
    test_full_rate();

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
